@@ hw/rtl/bpe_pkg.sv @@
package bpe_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W  = 24;
  localparam int IDX_IN_W = 3;
  localparam int CNT_W    = 4;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Point count after reset
  localparam logic [CNT_W-1:0] COUNT_RESET = 4'd4;

  // Coordinate saturation limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Binomial table: every degree a 4-bit count can select, C(15,7) fits 13 bits
  localparam int BN_W    = 4;
  localparam int BINOM_N = 16;
  localparam int BINOM_W = 13;

  typedef logic [BINOM_N*BINOM_N-1:0][BINOM_W-1:0] binom_tab_t;

  // Build Pascal's triangle row by row, entry {n, i} holds C(n, i)
  function automatic binom_tab_t binom_build();
    binom_tab_t tab;
    int         row [BINOM_N];
    for (int k = 0; k < BINOM_N; k++) begin
      row[k] = 0;
    end
    row[0] = 1;
    for (int n = 0; n < BINOM_N; n++) begin
      for (int k = BINOM_N - 1; k > 0; k--) begin
        if (k <= n) begin
          row[k] = row[k] + row[k-1];
        end
      end
      for (int k = 0; k < BINOM_N; k++) begin
        tab[n*BINOM_N + k] = BINOM_W'(row[k]);
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = binom_build();

  // Controller to datapath commands
  typedef struct packed {
    logic write_pt;
    logic load;
    logic pow_step;
    logic issue;
    logic finish;
  } bpe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pow_last;
    logic issue_last;
    logic pipe_empty;
  } bpe_sts_t;

endpackage

@@ hw/rtl/bezier_point_evaluator.sv @@
// Bezier curve point evaluator, Bernstein form, on up to MAX_POINTS control points.
// Requests: pulse start with the in_ fields while busy is low. in_op selects
// a point write (stores in_point_x/in_point_y at in_point_index, no result,
// busy stays low) or an evaluation at in_param_t (Q1.T_FRAC_BITS, clipped to 1.0).
// Configuration: cfg_point_count is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high. Write it only while busy is low.
// Results: out_curve_x/out_curve_y are valid for exactly one cycle while
// out_valid is high; the receiver cannot stall them and must take them then.
// Sequence: with n = point count - 1 (clipped to 1..MAX_POINTS-1), an evaluation
// runs n power-table steps through two multipliers, n+1 term issues into a
// three-stage weight/scale/accumulate pipeline, a drain of that pipeline and a
// rounding step. busy falls with out_valid, so the next request can be taken
// as soon as the result is presented.
// Reset (rst_n low, synchronous) idles the block, drops any pending result and
// sets the point count to 4. Stored points are undefined until written.
module bezier_point_evaluator #(
  parameter int MAX_POINTS  = 8,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [bpe_pkg::IDX_IN_W-1:0]        in_point_index,
  input  logic signed [bpe_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [bpe_pkg::COORD_W-1:0]  in_point_y,
  input  logic [T_FRAC_BITS:0]                in_param_t,
  output logic                                out_valid,
  output logic signed [bpe_pkg::COORD_W-1:0]  out_curve_x,
  output logic signed [bpe_pkg::COORD_W-1:0]  out_curve_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpe_pkg::CNT_W-1:0]           cfg_point_count
);
  import bpe_pkg::*;

  bpe_cmd_t cmd;
  bpe_sts_t sts;
  logic     cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  bpe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start & ~busy),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bpe_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_write       (cfg_write),
    .cfg_point_count (cfg_point_count),
    .in_point_index  (in_point_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_param_t      (in_param_t),
    .out_valid       (out_valid),
    .out_curve_x     (out_curve_x),
    .out_curve_y     (out_curve_y)
  );

  // A result only appears once the evaluation has ended
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of an evaluation");

  // An evaluate request occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_EVAL) |=> busy)
    else $error("evaluate request did not start work");

  // A point write leaves the block idle and yields no result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_WRITE) |=> !busy && !out_valid)
    else $error("point write produced activity");

endmodule

@@ hw/rtl/bpe_ctrl.sv @@
module bpe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  bpe_pkg::bpe_sts_t sts,
  output bpe_pkg::bpe_cmd_t cmd,
  output logic              busy
);
  import bpe_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POW   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Decode state into commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_EVAL) begin
            cmd.load  = 1'b1;
            state_nxt = ST_POW;
          end else begin
            cmd.write_pt = 1'b1;
          end
        end
      end
      ST_POW: begin
        cmd.pow_step = 1'b1;
        if (sts.pow_last) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ hw/rtl/bpe_datapath.sv @@
module bpe_datapath #(
  parameter int MAX_POINTS  = 8,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpe_pkg::bpe_cmd_t                   cmd,
  output bpe_pkg::bpe_sts_t                   sts,
  input  logic                                cfg_write,
  input  logic [bpe_pkg::CNT_W-1:0]           cfg_point_count,
  input  logic [bpe_pkg::IDX_IN_W-1:0]        in_point_index,
  input  logic signed [bpe_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [bpe_pkg::COORD_W-1:0]  in_point_y,
  input  logic [T_FRAC_BITS:0]                in_param_t,
  output logic                                out_valid,
  output logic signed [bpe_pkg::COORD_W-1:0]  out_curve_x,
  output logic signed [bpe_pkg::COORD_W-1:0]  out_curve_y
);
  import bpe_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int S_W    = T_FRAC_BITS + 1;
  localparam int MP_W   = 2 * S_W;
  localparam int WGT_W  = BINOM_W + S_W;
  localparam int PROD_W = WGT_W + 1 + COORD_W;
  localparam int ACC_W  = PROD_W + 5;

  localparam logic [S_W-1:0]           ONE      = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [MP_W-1:0]          HALF_MP  = MP_W'(1) << (T_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  HALF_ACC = ACC_W'(1) << (T_FRAC_BITS - 1);
  localparam logic [CNT_W:0]           MAX_CNT  = (CNT_W + 1)'(MAX_POINTS);
  localparam logic [CNT_W:0]           MIN_CNT  = (CNT_W + 1)'(2);

  // Product of two Q1.T values, rounded half up
  function automatic logic [S_W-1:0] mul_round(input logic [S_W-1:0] a,
                                               input logic [S_W-1:0] b);
    logic [MP_W-1:0] p;
    p = a * b + HALF_MP;
    return p[T_FRAC_BITS +: S_W];
  endfunction

  // Round the weighted sum to nearest and clip to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] s;
    s = (v + HALF_ACC) >>> T_FRAC_BITS;
    if (s > ACC_W'(COORD_MAX)) begin
      return COORD_MAX;
    end else if (s < ACC_W'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return COORD_W'(s);
  endfunction

  logic [CNT_W-1:0]           point_count_r;
  logic signed [COORD_W-1:0]  pts_x_r [MAX_POINTS];
  logic signed [COORD_W-1:0]  pts_y_r [MAX_POINTS];
  logic [S_W-1:0]             t_r, u_r;
  logic [S_W-1:0]             pt_last_r, pu_last_r;
  logic [S_W-1:0]             pt_r [MAX_POINTS];
  logic [S_W-1:0]             pu_r [MAX_POINTS];
  logic [IDX_W-1:0]           k_r, i_r, n_r;
  logic [2:0]                 vld_r;
  logic [S_W-1:0]             h_r;
  logic [BINOM_W-1:0]         binom_r;
  logic signed [COORD_W-1:0]  px1_r, py1_r, px2_r, py2_r;
  logic [WGT_W-1:0]           w_r;
  logic signed [PROD_W-1:0]   prodx_r, prody_r;
  logic signed [ACC_W-1:0]    acc_x_r, acc_y_r;
  logic signed [COORD_W-1:0]  out_x_r, out_y_r;
  logic                       out_valid_r;

  logic                       wr_ok;
  logic [IDX_W-1:0]           wr_idx;
  logic [CNT_W:0]             cnt_ext, cnt_clamp;
  logic [IDX_W-1:0]           n_load;
  logic [S_W-1:0]             t_sat;
  logic [S_W-1:0]             pt_step, pu_step;

  // Decode the point write, clamp the request parameters and form the power steps
  always_comb begin
    wr_ok     = (int'(in_point_index) < MAX_POINTS);
    wr_idx    = IDX_W'(in_point_index);
    cnt_ext   = {1'b0, point_count_r};
    cnt_clamp = (cnt_ext < MIN_CNT) ? MIN_CNT :
                (cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext;
    n_load    = IDX_W'(cnt_clamp - 1'b1);
    t_sat     = (in_param_t > ONE) ? ONE : in_param_t;
    pt_step   = mul_round(pt_last_r, t_r);
    pu_step   = mul_round(pu_last_r, u_r);
  end

  // Hold the point count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= COUNT_RESET;
    end else if (cfg_write) begin
      point_count_r <= cfg_point_count;
    end
  end

  // Store control points
  always_ff @(posedge clk) begin
    if (cmd.write_pt && wr_ok) begin
      pts_x_r[wr_idx] <= in_point_x;
      pts_y_r[wr_idx] <= in_point_y;
    end
  end

  // Set up the evaluation, build the power tables, issue points
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r       <= t_sat;
      u_r       <= ONE - t_sat;
      pt_last_r <= ONE;
      pu_last_r <= ONE;
      pt_r[0]   <= ONE;
      pu_r[0]   <= ONE;
      k_r       <= IDX_W'(1);
      i_r       <= '0;
      n_r       <= n_load;
    end
    if (cmd.pow_step) begin
      pt_last_r <= pt_step;
      pu_last_r <= pu_step;
      pt_r[k_r] <= pt_step;
      pu_r[k_r] <= pu_step;
      k_r       <= k_r + 1'b1;
    end
    if (cmd.issue) begin
      h_r     <= mul_round(pu_r[n_r - i_r], pt_r[i_r]);
      binom_r <= BINOM_TAB[{BN_W'(n_r), BN_W'(i_r)}];
      px1_r   <= pts_x_r[i_r];
      py1_r   <= pts_y_r[i_r];
      i_r     <= i_r + 1'b1;
    end
  end

  // Track which term stages hold work
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], cmd.issue};
    end
  end

  // Weight, scale the point, accumulate
  always_ff @(posedge clk) begin
    w_r     <= binom_r * h_r;
    px2_r   <= px1_r;
    py2_r   <= py1_r;
    prodx_r <= $signed({1'b0, w_r}) * px2_r;
    prody_r <= $signed({1'b0, w_r}) * py2_r;
    if (cmd.load) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (vld_r[2]) begin
      acc_x_r <= acc_x_r + ACC_W'(prodx_r);
      acc_y_r <= acc_y_r + ACC_W'(prody_r);
    end
  end

  // Round and register the result, held until the next evaluation finishes
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_x_r <= sat_coord(acc_x_r);
      out_y_r <= sat_coord(acc_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign sts.pow_last   = (k_r == n_r);
  assign sts.issue_last = (i_r == n_r);
  assign sts.pipe_empty = (vld_r == '0);

  assign out_valid   = out_valid_r;
  assign out_curve_x = out_x_r;
  assign out_curve_y = out_y_r;

endmodule
